FILE: src/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
// Used by every cau_* module and by complex_arith_unit; no dependencies.
`default_nettype none

package cau_pkg;

  localparam int OP_W   = 2;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int SUM_W  = 33;
  localparam int ADD_W  = 17;
  localparam int DIR_W  = 34;
  localparam int D_W    = 32;
  localparam int QB     = 17;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;
  localparam logic [OP_W-1:0] OP_DIV = 2'd3;

  localparam logic signed [VAL_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [VAL_W-1:0] SAT_MIN = 16'sh8000;

  // Per-item side information that rides along the divider stages.
  typedef struct packed {
    logic                    is_div;
    logic                    dz;
    logic                    neg_re;
    logic                    neg_im;
    logic                    big_re;
    logic                    big_im;
    logic signed [DIR_W-1:0] dir_re;
    logic signed [DIR_W-1:0] dir_im;
  } side_t;

endpackage

`default_nettype wire

FILE: src/cau_mult.sv
// First stage: the six operand products and the add/subtract results.
// Depends on cau_pkg.
`default_nettype none

module cau_mult (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [cau_pkg::OP_W-1:0]        op_i,
  input  logic signed [cau_pkg::VAL_W-1:0] a_re_i,
  input  logic signed [cau_pkg::VAL_W-1:0] a_im_i,
  input  logic signed [cau_pkg::VAL_W-1:0] b_re_i,
  input  logic signed [cau_pkg::VAL_W-1:0] b_im_i,
  output logic [cau_pkg::OP_W-1:0]        op_o,
  output logic signed [cau_pkg::PROD_W-1:0] p_rr_o,
  output logic signed [cau_pkg::PROD_W-1:0] p_ii_o,
  output logic signed [cau_pkg::PROD_W-1:0] p_ir_o,
  output logic signed [cau_pkg::PROD_W-1:0] p_ri_o,
  output logic signed [cau_pkg::PROD_W-1:0] p_br_o,
  output logic signed [cau_pkg::PROD_W-1:0] p_bi_o,
  output logic signed [cau_pkg::ADD_W-1:0]  add_re_o,
  output logic signed [cau_pkg::ADD_W-1:0]  add_im_o
);
  import cau_pkg::*;

  logic signed [ADD_W-1:0] add_re_d, add_im_d;

  always_comb begin
    if (op_i == OP_SUB) begin
      add_re_d = ADD_W'(a_re_i) - ADD_W'(b_re_i);
      add_im_d = ADD_W'(a_im_i) - ADD_W'(b_im_i);
    end else begin
      add_re_d = ADD_W'(a_re_i) + ADD_W'(b_re_i);
      add_im_d = ADD_W'(a_im_i) + ADD_W'(b_im_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_o     <= op_i;
      p_rr_o   <= a_re_i * b_re_i;
      p_ii_o   <= a_im_i * b_im_i;
      p_ir_o   <= a_im_i * b_re_i;
      p_ri_o   <= a_re_i * b_im_i;
      p_br_o   <= b_re_i * b_re_i;
      p_bi_o   <= b_im_i * b_im_i;
      add_re_o <= add_re_d;
      add_im_o <= add_im_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/cau_comb.sv
// Stages two and three: sums of products, product scaling, and the
// dividend magnitudes and divisor for the divider. Depends on cau_pkg.
`default_nettype none

module cau_comb #(
  parameter int FRAC_BITS = 8,
  parameter int NW        = 40
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [cau_pkg::OP_W-1:0]          op_i,
  input  logic signed [cau_pkg::PROD_W-1:0] p_rr_i,
  input  logic signed [cau_pkg::PROD_W-1:0] p_ii_i,
  input  logic signed [cau_pkg::PROD_W-1:0] p_ir_i,
  input  logic signed [cau_pkg::PROD_W-1:0] p_ri_i,
  input  logic signed [cau_pkg::PROD_W-1:0] p_br_i,
  input  logic signed [cau_pkg::PROD_W-1:0] p_bi_i,
  input  logic signed [cau_pkg::ADD_W-1:0]  add_re_i,
  input  logic signed [cau_pkg::ADD_W-1:0]  add_im_i,
  output cau_pkg::side_t                    side_o,
  output logic [NW-1:0]                     mag_re_o,
  output logic [NW-1:0]                     mag_im_o,
  output logic [cau_pkg::D_W-1:0]           d_o
);
  import cau_pkg::*;

  logic [OP_W-1:0]          op_q;
  logic signed [SUM_W-1:0]  mre_q, mim_q, nre_q, nim_q;
  logic [D_W-1:0]           d_q;
  logic signed [ADD_W-1:0]  add_re_q, add_im_q;

  // Stage two: combine products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q     <= op_i;
      mre_q    <= SUM_W'(p_rr_i) - SUM_W'(p_ii_i);
      mim_q    <= SUM_W'(p_ir_i) + SUM_W'(p_ri_i);
      nre_q    <= SUM_W'(p_rr_i) + SUM_W'(p_ii_i);
      nim_q    <= SUM_W'(p_ir_i) - SUM_W'(p_ri_i);
      d_q      <= D_W'(p_br_i) + D_W'(p_bi_i);
      add_re_q <= add_re_i;
      add_im_q <= add_im_i;
    end
  end

  side_t                  side_d;
  logic [PROD_W-1:0]      abs_re, abs_im;
  logic signed [SUM_W-1:0] neg_re_v, neg_im_v;

  always_comb begin
    neg_re_v = -nre_q;
    neg_im_v = -nim_q;
    abs_re   = nre_q[SUM_W-1] ? neg_re_v[PROD_W-1:0] : nre_q[PROD_W-1:0];
    abs_im   = nim_q[SUM_W-1] ? neg_im_v[PROD_W-1:0] : nim_q[PROD_W-1:0];

    side_d        = '0;
    side_d.is_div = (op_q == OP_DIV);
    side_d.dz     = (op_q == OP_DIV) && (d_q == '0);
    side_d.neg_re = nre_q[SUM_W-1];
    side_d.neg_im = nim_q[SUM_W-1];
    if (op_q == OP_MUL) begin
      side_d.dir_re = DIR_W'(mre_q >>> FRAC_BITS);
      side_d.dir_im = DIR_W'(mim_q >>> FRAC_BITS);
    end else begin
      side_d.dir_re = DIR_W'(add_re_q);
      side_d.dir_im = DIR_W'(add_im_q);
    end
  end

  // Stage three: scale the dividend magnitudes up by 2^FRAC_BITS.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o   <= side_d;
      mag_re_o <= NW'(abs_re) << FRAC_BITS;
      mag_im_o <= NW'(abs_im) << FRAC_BITS;
      d_o      <= d_q;
    end
  end

endmodule

`default_nettype wire

FILE: src/cau_div.sv
// Pipelined restoring divider for both result parts, one quotient bit
// per stage, plus a range check stage in front. Depends on cau_pkg.
`default_nettype none

module cau_div #(
  parameter int NW = 40
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  cau_pkg::side_t           side_i,
  input  logic [NW-1:0]            mag_re_i,
  input  logic [NW-1:0]            mag_im_i,
  input  logic [cau_pkg::D_W-1:0]  d_i,
  output cau_pkg::side_t           side_o,
  output logic [cau_pkg::QB-1:0]   q_re_o,
  output logic [cau_pkg::QB-1:0]   q_im_o
);
  import cau_pkg::*;

  localparam int RW = (NW > D_W + QB) ? NW : D_W + QB;

  logic [RW-1:0]   rre_q [0:QB];
  logic [RW-1:0]   rim_q [0:QB];
  logic [QB-1:0]   qre_q [0:QB];
  logic [QB-1:0]   qim_q [0:QB];
  logic [D_W-1:0]  d_q   [0:QB];
  side_t           sd_q  [0:QB];

  side_t         side_d;
  logic [RW-1:0] lim;

  // Quotients of 2^QB or more saturate anyway: flag them here.
  always_comb begin
    lim           = RW'(d_i) << QB;
    side_d        = side_i;
    side_d.big_re = (RW'(mag_re_i) >= lim);
    side_d.big_im = (RW'(mag_im_i) >= lim);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rre_q[0] <= RW'(mag_re_i);
      rim_q[0] <= RW'(mag_im_i);
      qre_q[0] <= '0;
      qim_q[0] <= '0;
      d_q[0]   <= d_i;
      sd_q[0]  <= side_d;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    localparam int K = QB - j;
    logic [RW-1:0] dsh;
    logic          ge_re, ge_im;

    always_comb begin
      dsh   = RW'(d_q[j-1]) << K;
      ge_re = (rre_q[j-1] >= dsh);
      ge_im = (rim_q[j-1] >= dsh);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rre_q[j] <= ge_re ? rre_q[j-1] - dsh : rre_q[j-1];
        rim_q[j] <= ge_im ? rim_q[j-1] - dsh : rim_q[j-1];
        qre_q[j] <= {qre_q[j-1][QB-2:0], ge_re};
        qim_q[j] <= {qim_q[j-1][QB-2:0], ge_im};
        d_q[j]   <= d_q[j-1];
        sd_q[j]  <= sd_q[j-1];
      end
    end
  end

  assign side_o = sd_q[QB];
  assign q_re_o = qre_q[QB];
  assign q_im_o = qim_q[QB];

endmodule

`default_nettype wire

FILE: src/cau_sat.sv
// Final stage: pick the direct or quotient result, apply sign, saturate
// to 16 bits and raise the flags. Depends on cau_pkg.
`default_nettype none

module cau_sat (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  cau_pkg::side_t                   side_i,
  input  logic [cau_pkg::QB-1:0]           q_re_i,
  input  logic [cau_pkg::QB-1:0]           q_im_i,
  output logic signed [cau_pkg::VAL_W-1:0] res_re_o,
  output logic signed [cau_pkg::VAL_W-1:0] res_im_o,
  output logic                             overflow_o,
  output logic                             div_zero_o
);
  import cau_pkg::*;

  logic signed [DIR_W-1:0] v_re, v_im, qv_re, qv_im;
  logic signed [VAL_W-1:0] s_re, s_im;
  logic                    o_re, o_im;

  always_comb begin
    // A quotient flagged as too big stands in as 2^QB with its sign.
    qv_re = side_i.big_re ? (DIR_W'(1) << QB) : DIR_W'(q_re_i);
    qv_im = side_i.big_im ? (DIR_W'(1) << QB) : DIR_W'(q_im_i);
    if (side_i.neg_re) qv_re = -qv_re;
    if (side_i.neg_im) qv_im = -qv_im;

    if (side_i.is_div) begin
      v_re = side_i.dz ? '0 : qv_re;
      v_im = side_i.dz ? '0 : qv_im;
    end else begin
      v_re = side_i.dir_re;
      v_im = side_i.dir_im;
    end

    o_re = 1'b1;
    o_im = 1'b1;
    if (v_re > DIR_W'(SAT_MAX))      s_re = SAT_MAX;
    else if (v_re < DIR_W'(SAT_MIN)) s_re = SAT_MIN;
    else begin
      s_re = v_re[VAL_W-1:0];
      o_re = 1'b0;
    end
    if (v_im > DIR_W'(SAT_MAX))      s_im = SAT_MAX;
    else if (v_im < DIR_W'(SAT_MIN)) s_im = SAT_MIN;
    else begin
      s_im = v_im[VAL_W-1:0];
      o_im = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_re_o   <= s_re;
      res_im_o   <= s_im;
      overflow_o <= o_re | o_im;
      div_zero_o <= side_i.dz;
    end
  end

endmodule

`default_nettype wire

FILE: src/complex_arith_unit.sv
// Top level of the complex arithmetic unit: add, subtract, multiply and divide
// of Q-format complex operands. Depends on cau_pkg and the cau_* stage modules.
//
//   Channel  Dir  tdata (low bit up)                   tuser
//   s_axis   in   a_re, a_im, b_re, b_im (64 bits)     req_type (2 bits)
//   m_axis   out  res_re, res_im (32 bits)             overflow, div_zero
//
// The pipeline has one product stage, two combine stages, one range
// check stage, 17 quotient stages (one bit each) and one saturate stage.
// Every operation takes the same path, so results leave in order.
// One item enters per cycle; the pipeline moves as a whole and holds
// only while a finished result waits on m_axis_tready.
// Reset clears the valid bits only; the data path holds no reset.
`default_nettype none

module complex_arith_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // a_re, a_im, b_re, b_im
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // res_re, res_im
  output logic [1:0]  m_axis_tuser    // overflow, div_zero
);
  import cau_pkg::*;

  localparam int NW  = PROD_W + FRAC_BITS;
  localparam int LAT = 4 + QB + 1;

  logic [LAT-1:0] v_q, v_d;
  logic           en;

  // Advance everything unless the output holds a result nobody takes.
  assign en            = !v_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[LAT-1];
  assign v_d           = {v_q[LAT-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  logic [OP_W-1:0]          m_op;
  logic signed [PROD_W-1:0] p_rr, p_ii, p_ir, p_ri, p_br, p_bi;
  logic signed [ADD_W-1:0]  add_re, add_im;

  cau_mult u_mult (
    .clk_i    (clk_i),
    .en_i     (en),
    .op_i     (s_axis_tuser),
    .a_re_i   (s_axis_tdata[15:0]),
    .a_im_i   (s_axis_tdata[31:16]),
    .b_re_i   (s_axis_tdata[47:32]),
    .b_im_i   (s_axis_tdata[63:48]),
    .op_o     (m_op),
    .p_rr_o   (p_rr),
    .p_ii_o   (p_ii),
    .p_ir_o   (p_ir),
    .p_ri_o   (p_ri),
    .p_br_o   (p_br),
    .p_bi_o   (p_bi),
    .add_re_o (add_re),
    .add_im_o (add_im)
  );

  side_t          c_side, d_side;
  logic [NW-1:0]  mag_re, mag_im;
  logic [D_W-1:0] dvs;

  cau_comb #(
    .FRAC_BITS (FRAC_BITS),
    .NW        (NW)
  ) u_comb (
    .clk_i    (clk_i),
    .en_i     (en),
    .op_i     (m_op),
    .p_rr_i   (p_rr),
    .p_ii_i   (p_ii),
    .p_ir_i   (p_ir),
    .p_ri_i   (p_ri),
    .p_br_i   (p_br),
    .p_bi_i   (p_bi),
    .add_re_i (add_re),
    .add_im_i (add_im),
    .side_o   (c_side),
    .mag_re_o (mag_re),
    .mag_im_o (mag_im),
    .d_o      (dvs)
  );

  logic [QB-1:0] q_re, q_im;

  cau_div #(
    .NW (NW)
  ) u_div (
    .clk_i    (clk_i),
    .en_i     (en),
    .side_i   (c_side),
    .mag_re_i (mag_re),
    .mag_im_i (mag_im),
    .d_i      (dvs),
    .side_o   (d_side),
    .q_re_o   (q_re),
    .q_im_o   (q_im)
  );

  logic signed [VAL_W-1:0] res_re, res_im;
  logic                    ovf, dz;

  cau_sat u_sat (
    .clk_i      (clk_i),
    .en_i       (en),
    .side_i     (d_side),
    .q_re_i     (q_re),
    .q_im_i     (q_im),
    .res_re_o   (res_re),
    .res_im_o   (res_im),
    .overflow_o (ovf),
    .div_zero_o (dz)
  );

  assign m_axis_tdata = {res_im, res_re};
  assign m_axis_tuser = {dz, ovf};

endmodule

`default_nettype wire

FILE: verif/cau_checker.sv
// Checker for the complex arithmetic unit: watches both stream channels,
// predicts each result from the accepted operands and compares. Needs cau_pkg.
module cau_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  typedef struct packed {
    logic [1:0]  flags;   // overflow, div_zero from the low bit up
    logic [31:0] parts;   // res_re, res_im
  } cau_result_t;

  localparam int FB = 8;

  cau_result_t result_q[$];

  function automatic logic [15:0] clamp16(input longint v, inout logic ovf);
    if (v > 32767) begin
      ovf = 1'b1;
      return 16'h7fff;
    end
    if (v < -32768) begin
      ovf = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic cau_result_t compute_result(input logic [1:0] op,
                                                 input logic [63:0] d);
    longint ar, ai, br, bi, re, im, den;
    logic ovf, dz;
    cau_result_t r;
    ar = longint'($signed(d[15:0]));
    ai = longint'($signed(d[31:16]));
    br = longint'($signed(d[47:32]));
    bi = longint'($signed(d[63:48]));
    re = 0;
    im = 0;
    ovf = 1'b0;
    dz = 1'b0;
    case (op)
      OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      OP_MUL: begin
        // >>> on signed longint floors, as required
        re = (ar * br - ai * bi) >>> FB;
        im = (ai * br + ar * bi) >>> FB;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) dz = 1'b1;
        else begin
          // integer division truncates toward zero
          re = ((ar * br + ai * bi) * (64'sd1 << FB)) / den;
          im = ((ai * br - ar * bi) * (64'sd1 << FB)) / den;
        end
      end
    endcase
    r.parts[15:0]  = clamp16(re, ovf);
    r.parts[31:16] = clamp16(im, ovf);
    r.flags = {dz, ovf};
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cau_result_t want;
    if (!rst_ni) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        result_q.push_back(compute_result(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h/%b", m_axis_tdata, m_axis_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = result_q.pop_front();
          if (want.parts !== m_axis_tdata || want.flags !== m_axis_tuser) begin
            if (fail_count < 10)
              $display("mismatch: want re %h im %h ovf %b dz %b, got re %h im %h ovf %b dz %b",
                       want.parts[15:0], want.parts[31:16], want.flags[0], want.flags[1],
                       m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser[0],
                       m_axis_tuser[1]);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= result_q.size();
    end
  end
endmodule

FILE: verif/tb_complex_arith_unit.sv
// Testbench top for complex_arith_unit: drives operand items with random
// gaps and back-pressure; cau_checker predicts and compares. Needs cau_pkg.
module tb_complex_arith_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  localparam int N_RANDOM = 1900;
  localparam int LATENCY  = 22;
  localparam int LIMIT    = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = OP_ADD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          quiet_tail = 1'b0;   // no idling in the last part of the run
  bit          hold_sink = 1'b0;    // long receiver hold-off request
  bit          sink_held = 1'b0;

  complex_arith_unit DUT (.*);

  cau_checker u_checker (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: count cycles, give up at a generous limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("tb_complex_arith_unit: errors");
      $finish;
    end
  end

  // Pick an operand value, weighted toward the extremes and zero.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom());
    endcase
  endfunction

  // Offer one item and hold it until accepted.
  task automatic send_item(input logic [1:0] op, input logic [63:0] data);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid for a random burst now and then.
  task automatic maybe_gap();
    int n;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink && !sink_held) begin
        sink_held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (200) @(negedge clk_i);
      end
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 16);
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [15:0] ext[4];
    logic [63:0] d;
    ext = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: every operation on extreme operands, zero divisors.
    for (int op = 0; op < 4; op++) begin
      for (int k = 0; k < 4; k++)
        send_item(op[1:0], {ext[k], ext[3 - k], ext[(k + 1) % 4], ext[k]});
      send_item(op[1:0], {16'h0000, 16'h0000, 16'h0180, 16'hfe80});
    end
    send_item(OP_DIV, {32'h0000_0000, 16'h8000, 16'h7fff});
    send_item(OP_DIV, 64'hffff_ffff_0000_0000);
    send_item(OP_DIV, {16'h0000, 16'h0001, 16'h7fff, 16'h7fff});
    s_axis_tvalid <= 1'b0;

    // Pause until every expected result has come.
    while (pending != 0) @(negedge clk_i);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_sink = 1'b1;          // block fills and stalls input
      if (i == N_RANDOM - 200) quiet_tail = 1'b1;
      d = {pick_value(), pick_value(), pick_value(), pick_value()};
      if ($urandom_range(0, 15) == 0) d[63:32] = '0;   // zero divisor
      send_item(2'($urandom_range(0, 3)), d);
      maybe_gap();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);
    if (fail_count == 0)
      $display("tb_complex_arith_unit: clean");
    else
      $display("tb_complex_arith_unit: errors");
    $finish;
  end
endmodule

FILE: sim.f
src/cau_pkg.sv
src/cau_mult.sv
src/cau_comb.sv
src/cau_div.sv
src/cau_sat.sv
src/complex_arith_unit.sv
verif/cau_checker.sv
verif/tb_complex_arith_unit.sv
